// ===== hw/rtl/sbfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder package
// Shared types, field widths and scaling constants of the frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int FRAME_LEN   = 25;
    localparam int STORE_LEN   = FRAME_LEN - 1;
    localparam int POS_W       = 5;
    localparam int NUM_RAW     = 10;
    localparam int NUM_CHAN    = 6;
    localparam int NUM_SW      = NUM_RAW - NUM_CHAN;
    localparam int CH_W        = 11;
    localparam int SW_W        = 2;
    localparam int IDX_W       = 3;
    localparam int FLAG_BYTE   = 23;
    localparam int LOST_BIT    = 2;
    localparam int FS_BIT      = 3;
    localparam int PACK_BYTES  = 14;

    localparam logic [7:0] HEAD_BYTE = 8'h0F;
    localparam logic [7:0] TAIL_BYTE = 8'h00;
    localparam logic [CH_W-1:0] CENTRE = 11'd1024;

    localparam int P_W         = 21;
    localparam int Q_W         = 10;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 32;
    localparam int SCALE_MUL   = 1320;
    localparam int SCALE_OFS   = 783;
    localparam longint DIV_POS = 1566;
    localparam longint DIV_NEG = 1568;
    localparam longint RECIP_POS_L = ((64'sd1 <<< RECIP_SHIFT) + DIV_POS - 1) / DIV_POS;
    localparam longint RECIP_NEG_L = ((64'sd1 <<< RECIP_SHIFT) + DIV_NEG - 1) / DIV_NEG;
    localparam logic [RECIP_W-1:0] RECIP_POS = RECIP_W'(RECIP_POS_L);
    localparam logic [RECIP_W-1:0] RECIP_NEG = RECIP_W'(RECIP_NEG_L);

    localparam logic [SW_W-1:0] SW_LOW  = 2'b01;
    localparam logic [SW_W-1:0] SW_HIGH = 2'b11;
    localparam logic [SW_W-1:0] SW_MID  = 2'b00;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                              lost;
        logic                              failsafe;
        logic [NUM_RAW-1:0][CH_W-1:0]      raw;
    } t_frame;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage

// ===== hw/rtl/sbfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder queue
// Small first-in first-out buffer between the byte front end and the
// channel back end.
// ----------------------------------------------------------------------------
module sbfd_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hw/rtl/sbfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder front end
// Tracks the byte position, stores frame bytes and, on the last byte of a
// frame with a good head and tail, pushes the raw channels and flags.
// ----------------------------------------------------------------------------
module sbfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sbfd_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [sbfd_pkg::IN_USER_W-1:0] i_s_tuser,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output sbfd_pkg::t_frame             o_q_data
);

    import sbfd_pkg::*;

    logic [POS_W-1:0]               r_pos, n_pos;
    logic [7:0]                     r_frame [STORE_LEN];
    logic [POS_W-1:0]               w_pos_eff;
    logic                           w_accept;
    logic [PACK_BYTES*8-1:0]        w_packed;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pos_eff  = i_s_tuser[0] ? '0 : r_pos;

    always_comb begin
        n_pos    = r_pos;
        o_q_push = 1'b0;
        if (w_accept && (w_pos_eff < POS_W'(FRAME_LEN))) begin
            n_pos = w_pos_eff + 1'b1;
            if (w_pos_eff == POS_W'(FRAME_LEN - 1)) begin
                o_q_push = (r_frame[0] == HEAD_BYTE) && (i_s_tdata == TAIL_BYTE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_W'(FRAME_LEN);
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_pos_eff < POS_W'(STORE_LEN))) begin
            r_frame[w_pos_eff] <= i_s_tdata;
        end
    end

    always_comb begin
        for (int i = 0; i < PACK_BYTES; i++) begin
            w_packed[i*8 +: 8] = r_frame[i + 1];
        end
        for (int k = 0; k < NUM_RAW; k++) begin
            o_q_data.raw[k] = w_packed[k*CH_W +: CH_W];
        end
        o_q_data.lost     = r_frame[FLAG_BYTE][LOST_BIT];
        o_q_data.failsafe = r_frame[FLAG_BYTE][FS_BIT];
    end

endmodule

// ===== hw/rtl/sbfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder back end
// Scales the six proportional channels one per cycle through a three-stage
// reciprocal multiply, derives the switches and holds the result beat.
// ----------------------------------------------------------------------------
module sbfd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_map_enable,
    input  logic                          i_q_empty,
    input  sbfd_pkg::t_frame              i_q_data,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [sbfd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [sbfd_pkg::OUT_USER_W-1:0] o_m_tuser
);

    import sbfd_pkg::*;

    t_back_state                r_state, n_state;
    t_frame                     r_cur;
    logic [IDX_W-1:0]           r_idx;
    logic                       w_feed;
    logic                       w_out_free;
    logic                       w_load;

    logic [CH_W-1:0]            w_raw;
    logic                       w_neg;
    logic [CH_W-1:0]            w_mag;

    logic                       r_s1_valid;
    logic [IDX_W-1:0]           r_s1_idx;
    logic                       r_s1_neg;
    logic [CH_W-1:0]            r_s1_cent;
    logic [P_W-1:0]             r_s1_p;

    logic [P_W+RECIP_W-1:0]     w_prod;
    logic                       r_s2_valid;
    logic [IDX_W-1:0]           r_s2_idx;
    logic                       r_s2_neg;
    logic [CH_W-1:0]            r_s2_cent;
    logic [Q_W-1:0]             r_s2_q;

    logic [CH_W-1:0]            w_scaled;
    logic [CH_W-1:0]            w_final;
    logic [CH_W-1:0]            r_chan [NUM_CHAN];

    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;
    logic [OUT_USER_W-1:0]      r_out_user;
    logic [OUT_DATA_W-1:0]      w_pack;

    assign w_feed     = (r_state == BK_RUN) && (r_idx < IDX_W'(NUM_CHAN));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_load     = (r_state == BK_DONE) && w_out_free;
    assign o_q_pop    = (r_state == BK_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_s2_valid && (r_s2_idx == IDX_W'(NUM_CHAN - 1))) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= w_feed;
            r_s2_valid <= r_s1_valid;
            if (o_q_pop) begin
                r_idx <= '0;
            end else if (w_feed) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_raw = r_cur.raw[{1'b0, r_idx}];
    assign w_neg = (w_raw < CENTRE);
    assign w_mag = w_neg ? (CENTRE - w_raw) : (w_raw - CENTRE);

    assign w_prod = {{RECIP_W{1'b0}}, r_s1_p}
                  * {{P_W{1'b0}}, (r_s1_neg ? RECIP_NEG : RECIP_POS)};

    assign w_scaled = r_s2_neg ? (CH_W'(0) - {1'b0, r_s2_q}) : {1'b0, r_s2_q};

    always_comb begin
        w_final = i_map_enable ? w_scaled : r_s2_cent;
        if (r_cur.failsafe) begin
            w_final = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
        r_s1_idx  <= r_idx;
        r_s1_neg  <= w_neg;
        r_s1_cent <= {~w_raw[CH_W-1], w_raw[CH_W-2:0]};
        r_s1_p    <= P_W'(w_mag) * P_W'(SCALE_MUL) + P_W'(SCALE_OFS);
        r_s2_idx  <= r_s1_idx;
        r_s2_neg  <= r_s1_neg;
        r_s2_cent <= r_s1_cent;
        r_s2_q    <= w_prod[RECIP_SHIFT +: Q_W];
        if (r_s2_valid) begin
            r_chan[r_s2_idx] <= w_final;
        end
    end

    always_comb begin
        w_pack = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            w_pack[k*CH_W +: CH_W] = r_chan[k];
        end
        for (int j = 0; j < NUM_SW; j++) begin
            if (r_cur.raw[NUM_CHAN + j] < CENTRE) begin
                w_pack[NUM_CHAN*CH_W + j*SW_W +: SW_W] = SW_LOW;
            end else if (r_cur.raw[NUM_CHAN + j] > CENTRE) begin
                w_pack[NUM_CHAN*CH_W + j*SW_W +: SW_W] = SW_HIGH;
            end else begin
                w_pack[NUM_CHAN*CH_W + j*SW_W +: SW_W] = SW_MID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_pack;
            r_out_user <= {r_cur.failsafe, r_cur.lost};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== hw/rtl/sbus_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio control frame decoder
// Decodes 25-byte serial radio frames into six scaled channels, four
// three-way switches and the lost-frame and failsafe flags.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the slave stream, one byte per beat; tuser bit 0 marks
// byte 0 of a frame and restarts the byte count. Bytes outside a frame are
// dropped. Every beat is accepted in the cycle it is offered while the frame queue has room.
// After the 25th byte, a frame with head 0x0F and tail 0x00 yields one beat on
// the master stream; any other frame yields none. The six channels pass one
// per cycle through a three-stage scaling pipeline that the back end shares.
// The back end decodes one frame at a time, faster than its bytes arrive,
// and takes the next once the last result beat is loaded. The configuration
// channel sets map_enable (1 scales the channels to about +-862, 0 passes
// centred raw values); write it only while the block is idle. Reset sets
// map_enable to 1, empties the queue and waits for a start byte. When the
// receiver stalls, the result beat is held, the back end keeps one more
// frame, up to QUEUE_DEPTH wait in the queue, then the slave side stalls.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
    parameter int QUEUE_DEPTH = sbfd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // rx_byte
    input  logic [sbfd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // frame_start
    input  logic [sbfd_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // chan_a, chan_b, chan_c, chan_d, chan_e, chan_f, switch_a, switch_b,
    // switch_c, switch_d, zero fill
    output logic [sbfd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // link_lost, failsafe_on
    output logic [sbfd_pkg::OUT_USER_W-1:0] o_m_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);

    import sbfd_pkg::*;

    logic   r_map_enable;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_q_push;
    logic   w_q_pop;
    t_frame w_q_in;
    t_frame w_q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_map_enable <= i_cfg_data;
        end
    end

    sbfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    sbfd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_frame))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    sbfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_map_enable (r_map_enable),
        .i_q_empty    (w_q_empty),
        .i_q_data     (w_q_out),
        .o_q_pop      (w_q_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

// ===== sim/sbus_frame_decoder_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder checker
// Watches the byte stream, the configuration channel and the result stream of
// the frame decoder. It keeps its own copy of the frame bytes, the byte
// position and the mapping switch, decodes every complete frame with a valid
// head and tail, and compares each result beat field by field with the oldest
// decoded frame still waiting.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [sbfd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [sbfd_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sbfd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [sbfd_pkg::OUT_USER_W-1:0] i_m_tuser,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic                            i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending,
    output int                              o_decoded
);

    import sbfd_pkg::*;

    localparam int FIELD_W = 2 + NUM_SW * SW_W + NUM_CHAN * CH_W;

    typedef struct packed {
        logic                         failsafe;
        logic                         lost;
        logic [NUM_SW-1:0][SW_W-1:0]  sw;
        logic [NUM_CHAN-1:0][CH_W-1:0] chan;
    } t_decoded_frame;

    logic [FRAME_LEN*8-1:0] frame_bits = '0;
    int                     write_pos  = FRAME_LEN;
    logic                   map_on     = 1'b1;
    t_decoded_frame         expected_frames[$];
    int                     err_total  = 0;
    int                     beat_total = 0;

    function automatic int scale_stick(input int v);
        int n;
        if (v >= 0) begin
            return (SCALE_MUL * v + 783) / 1566;
        end
        n = SCALE_MUL * v + 784;
        if (n >= 0) begin
            return n / 1568;
        end
        return -((-n + 1567) / 1568);
    endfunction

    function automatic t_decoded_frame decode_frame(input logic [FRAME_LEN*8-1:0] fr,
                                                    input logic map_en);
        t_decoded_frame r;
        logic [CH_W-1:0] raw;
        logic [7:0]      flags;
        int              v;
        flags      = fr[8*FLAG_BYTE +: 8];
        r.lost     = flags[LOST_BIT];
        r.failsafe = flags[FS_BIT];
        for (int k = 0; k < NUM_CHAN; k++) begin
            raw = fr[8 + CH_W*k +: CH_W];
            v   = int'(raw) - 1024;
            if (map_en) begin
                v = scale_stick(v);
            end
            if (r.failsafe) begin
                v = 0;
            end
            r.chan[k] = CH_W'(v);
        end
        for (int k = NUM_CHAN; k < NUM_RAW; k++) begin
            raw = fr[8 + CH_W*k +: CH_W];
            if (raw < CENTRE) begin
                r.sw[k-NUM_CHAN] = SW_LOW;
            end else if (raw > CENTRE) begin
                r.sw[k-NUM_CHAN] = SW_HIGH;
            end else begin
                r.sw[k-NUM_CHAN] = SW_MID;
            end
        end
        return r;
    endfunction

    function automatic void compare_beat(input t_decoded_frame want,
                                         input t_decoded_frame got,
                                         input logic [OUT_DATA_W-FIELD_W+1:0] fill);
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (got.chan[k] !== want.chan[k]) begin
                $display("%0t: channel %0d expected %0d, actual %0d", $time, k + 1,
                         $signed(want.chan[k]), $signed(got.chan[k]));
                err_total++;
            end
        end
        for (int k = 0; k < NUM_SW; k++) begin
            if (got.sw[k] !== want.sw[k]) begin
                $display("%0t: switch %0d expected %0d, actual %0d", $time, k + 1,
                         $signed(want.sw[k]), $signed(got.sw[k]));
                err_total++;
            end
        end
        if (got.lost !== want.lost) begin
            $display("%0t: link_lost expected %0b, actual %0b", $time, want.lost, got.lost);
            err_total++;
        end
        if (got.failsafe !== want.failsafe) begin
            $display("%0t: failsafe_on expected %0b, actual %0b", $time,
                     want.failsafe, got.failsafe);
            err_total++;
        end
        if (fill !== '0) begin
            $display("%0t: zero fill expected 0, actual %h", $time, fill);
            err_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_decoded_frame got;
        if (!i_rst_n) begin
            write_pos = FRAME_LEN;
            map_on    = 1'b1;
            expected_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                map_on = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) begin
                    write_pos = 0;
                end
                if (write_pos < FRAME_LEN) begin
                    frame_bits[8*write_pos +: 8] = i_s_tdata;
                    write_pos++;
                    if (write_pos == FRAME_LEN && frame_bits[7:0] == HEAD_BYTE
                            && frame_bits[8*(FRAME_LEN-1) +: 8] == TAIL_BYTE) begin
                        expected_frames.push_back(decode_frame(frame_bits, map_on));
                    end
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                beat_total++;
                got = {i_m_tuser[1], i_m_tuser[0], i_m_tdata[FIELD_W-3:0]};
                if (expected_frames.size() == 0) begin
                    $display("%0t: result beat expected none, actual %h_%h", $time,
                             i_m_tuser, i_m_tdata);
                    err_total++;
                end else begin
                    compare_beat(expected_frames.pop_front(), got,
                                 i_m_tdata[OUT_DATA_W-1:FIELD_W-2]);
                end
            end
        end
        o_err_count <= err_total;
        o_pending   <= expected_frames.size();
        o_decoded   <= beat_total;
    end

endmodule

// ===== sim/sbus_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder testbench
// Feeds the frame decoder with directed frames at the channel extremes and
// then with random frames, bad frames, cut frames and stray bytes under both
// mapping settings, with random gaps and stalls on both streams. A checker
// beside the decoder predicts and compares every result beat.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;
    import sbfd_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int RAND_BYTES = 1600;
    localparam int NUM_PHASES = 4;

    typedef logic [NUM_SLOTS-1:0][CH_W-1:0] t_raw_set;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    bit calm      = 1'b0;
    bit last_cut  = 1'b0;
    int err_count;
    int pending;
    int decoded;
    int byte_count  = 0;
    int frame_count = 0;
    int good_count  = 0;
    int bad_count   = 0;
    int cut_count   = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sbus_frame_decoder uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    sbus_frame_decoder_chk check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .o_err_count(err_count),
        .o_pending  (pending),
        .o_decoded  (decoded)
    );

    always @(posedge clk) begin
        m_tready <= (!calm && $urandom_range(0, 99) < 10) ? 1'b0 : 1'b1;
    end

    task automatic send_beat(input logic [7:0] data, input logic start);
        while (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= data;
        s_tuser[0] <= start;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_frame(input t_raw_set raws, input logic [7:0] flags,
                              input logic [7:0] head, input logic [7:0] tail,
                              input int n_bytes);
        logic [FRAME_LEN*8-1:0] bits;
        bits = {tail, flags, raws, head};
        for (int i = 0; i < n_bytes; i++) begin
            send_beat(bits[8*i +: 8], i == 0);
        end
        byte_count  += n_bytes;
        frame_count++;
        last_cut = (n_bytes < FRAME_LEN);
    endtask

    task automatic send_stray(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge clk);
            guard++;
        end while (pending != 0 && guard < 5000);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_map(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CENTRE;
            3:       return CENTRE - 11'd1;
            4:       return CENTRE + 11'd1;
            default: return CH_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic t_raw_set random_raws();
        t_raw_set r;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            r[k] = pick_raw();
        end
        return r;
    endfunction

    task automatic random_frame();
        int         kind;
        t_raw_set   raws;
        logic [7:0] flags;
        logic [7:0] head;
        kind  = $urandom_range(0, 99);
        raws  = random_raws();
        flags = 8'($urandom_range(0, 255));
        if (kind >= 93 && !last_cut) begin
            send_stray($urandom_range(1, 4));
        end else if (kind < 78 || kind >= 93) begin
            send_frame(raws, flags, HEAD_BYTE, TAIL_BYTE, FRAME_LEN);
            good_count++;
        end else if (kind < 86) begin
            if ($urandom_range(0, 1) == 0) begin
                head = 8'($urandom_range(0, 255));
                if (head == HEAD_BYTE) begin
                    head = ~head;
                end
                send_frame(raws, flags, head, TAIL_BYTE, FRAME_LEN);
            end else begin
                send_frame(raws, flags, HEAD_BYTE, 8'($urandom_range(1, 255)), FRAME_LEN);
            end
            bad_count++;
        end else begin
            head = ($urandom_range(0, 1) == 0) ? HEAD_BYTE : 8'($urandom_range(0, 255));
            send_frame(raws, flags, head, TAIL_BYTE, $urandom_range(1, FRAME_LEN - 1));
            cut_count++;
        end
    endtask

    task automatic directed_frames();
        send_frame({NUM_SLOTS{11'h7FF}}, 8'h00, HEAD_BYTE, TAIL_BYTE, FRAME_LEN);
        send_frame({NUM_SLOTS{11'h000}}, 8'h04, HEAD_BYTE, TAIL_BYTE, FRAME_LEN);
        send_frame({NUM_SLOTS{CENTRE}}, 8'h08, HEAD_BYTE, TAIL_BYTE, FRAME_LEN);
        send_frame(random_raws(), 8'hFF, HEAD_BYTE, TAIL_BYTE, FRAME_LEN);
        good_count += 4;
    endtask

    initial begin
        int goal;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray bytes while idle, a frame cut short by a new start, then the
        // channel extremes with mapping at its reset value.
        send_stray(2);
        send_frame({NUM_SLOTS{11'h7FF}}, 8'h00, HEAD_BYTE, TAIL_BYTE, 4);
        cut_count++;
        directed_frames();
        send_frame({NUM_SLOTS{11'h7FF}}, 8'hFF, 8'h0E, TAIL_BYTE, FRAME_LEN);
        send_frame({NUM_SLOTS{11'h000}}, 8'h00, HEAD_BYTE, 8'h80, FRAME_LEN);
        bad_count += 2;
        drain();
        write_map(1'b0);
        directed_frames();
        drain();
        write_map(1'b1);

        goal = byte_count;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_map((p < 2) ? 1'(p) : 1'($urandom_range(0, 1)));
            calm = (p == 2);
            while (byte_count < goal + (p + 1) * RAND_BYTES / NUM_PHASES) begin
                random_frame();
            end
        end
        drain();
        calm = 1'b0;

        $display("Sent %0d frame bytes in %0d frames: %0d good, %0d bad head or tail, %0d cut.",
                 byte_count, frame_count, good_count, bad_count, cut_count);
        $display("Checked %0d decoded beats with mapping on and off; %0d still outstanding.",
                 decoded, pending);
        if (err_count == 0 && pending == 0) begin
            $display("** sbus_frame_decoder: PASSED **");
        end else begin
            $display("** sbus_frame_decoder: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Run timed out at %0t.", $time);
        $display("** sbus_frame_decoder: FAILED **");
        $finish;
    end

endmodule
